>>> design/i2c_master_transaction_engine_defines.svh
// Assertion macros for the I2C master transaction engine.
`ifndef I2C_MASTER_TRANSACTION_ENGINE_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define I2C_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define I2C_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define I2C_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define I2C_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> design/i2c_pkg.sv
`default_nettype none
package i2c_pkg;
  localparam int WriteBufDepth = 16;
  localparam int MaxReadLen = 255;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_LOAD = 2'd1;
  localparam logic [1:0] REQ_LAUNCH = 2'd2;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_WR_RD = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NACK = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ENABLE = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE, PH_S0, PH_S1, PH_S2, PH_W0, PH_W1, PH_W2,
    PH_A0, PH_A1, PH_A2, PH_A3OK, PH_A3NK,
    PH_R0, PH_R1, PH_R2, PH_K0, PH_K1, PH_K2,
    PH_P0, PH_P1, PH_FIN
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       sda_in;
    logic [7:0] wr_byte;
    logic [6:0] dev_address;
    logic [1:0] xfer_mode;
    logic [4:0] write_len;
    logic [7:0] read_len;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       rd_last;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;
endpackage
`default_nettype wire

>>> design/i2c_fifo.sv
`default_nettype none
// Short queue between the front and back parts.
module i2c_fifo #(
  parameter int Width = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [Width-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [Width-1:0] out_data
);
  logic [Width-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> design/i2c_engine.sv
`default_nettype none
// Back part: the bus sequencer, one input item per cycle unless the result is stalled, registered result.
module i2c_engine #(
  parameter int WriteBufDepth = i2c_pkg::WriteBufDepth,
  parameter int MaxReadLen = i2c_pkg::MaxReadLen
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire i2c_pkg::in_item_t   item,
  input  wire logic [15:0]         half_period_ticks,
  input  wire logic                bus_enable,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output i2c_pkg::out_item_t       res
);
  localparam int BufAw = (WriteBufDepth > 1) ? $clog2(WriteBufDepth) : 1;
  localparam int FillW = $clog2(WriteBufDepth + 1);
  localparam int RdW = $clog2(MaxReadLen + 1);

  logic [7:0] wbuf [WriteBufDepth];

  i2c_pkg::phase_t phase, phase_next;
  logic [15:0]  delay_count, delay_count_next;
  logic [2:0]   bit_index, bit_index_next;
  logic [7:0]   shift_reg, shift_reg_next;
  logic [FillW-1:0] buffer_fill, buffer_fill_next;
  logic [FillW-1:0] byte_index, byte_index_next;
  logic [FillW-1:0] write_count, write_count_next;
  logic [RdW-1:0] reads_left, reads_left_next;
  logic [6:0]   target_address, target_address_next;
  logic [1:0]   active_mode, active_mode_next;
  logic         scl_level, scl_level_next;
  logic         sda_level, sda_level_next;
  logic         read_part, read_part_next;
  logic         nack_seen, nack_seen_next;
  logic         wr_en;
  i2c_pkg::out_item_t res_next;
  logic         take;
  logic [15:0]  hd, qd;
  logic [7:0]   buf_rd;
  logic         bad;
  logic [RdW-1:0] rlen_sat;

  assign item_ready = !res_valid || res_ready;
  assign take = item_valid && item_ready;
  assign hd = (half_period_ticks == 16'd0) ? 16'd0 : half_period_ticks - 16'd1;
  assign qd = (half_period_ticks[15:1] == 15'd0) ? 16'd0
            : {1'b0, half_period_ticks[15:1]} - 16'd1;
  assign buf_rd = wbuf[byte_index[BufAw-1:0]];
  assign rlen_sat = ({24'd0, item.read_len} > 32'(MaxReadLen)) ? RdW'(MaxReadLen)
                  : RdW'(item.read_len);

  always_comb begin
    phase_next = phase;
    delay_count_next = delay_count;
    bit_index_next = bit_index;
    shift_reg_next = shift_reg;
    buffer_fill_next = buffer_fill;
    byte_index_next = byte_index;
    write_count_next = write_count;
    reads_left_next = reads_left;
    target_address_next = target_address;
    active_mode_next = active_mode;
    scl_level_next = scl_level;
    sda_level_next = sda_level;
    read_part_next = read_part;
    nack_seen_next = nack_seen;
    wr_en = 1'b0;
    res_next = '0;
    bad = 1'b0;
    case (item.req_type)
      i2c_pkg::REQ_TICK: begin
        if (phase != i2c_pkg::PH_IDLE) begin
          if (delay_count != 16'd0) begin
            delay_count_next = delay_count - 16'd1;
          end else begin
            case (phase)
              i2c_pkg::PH_S0: begin
                sda_level_next = 1'b1; scl_level_next = 1'b1;
                delay_count_next = hd; phase_next = i2c_pkg::PH_S1;
              end
              i2c_pkg::PH_S1: begin
                sda_level_next = 1'b0; delay_count_next = hd; phase_next = i2c_pkg::PH_S2;
              end
              i2c_pkg::PH_S2: begin
                scl_level_next = 1'b0; delay_count_next = hd;
                shift_reg_next = {target_address, read_part};
                bit_index_next = 3'd7; phase_next = i2c_pkg::PH_W0;
              end
              i2c_pkg::PH_W0: begin
                sda_level_next = shift_reg[bit_index]; delay_count_next = qd;
                phase_next = i2c_pkg::PH_W1;
              end
              i2c_pkg::PH_W1: begin
                scl_level_next = 1'b1; delay_count_next = hd; phase_next = i2c_pkg::PH_W2;
              end
              i2c_pkg::PH_W2: begin
                scl_level_next = 1'b0; delay_count_next = qd;
                if (bit_index == 3'd0) begin
                  phase_next = i2c_pkg::PH_A0;
                end else begin
                  bit_index_next = bit_index - 3'd1; phase_next = i2c_pkg::PH_W0;
                end
              end
              i2c_pkg::PH_A0: begin
                sda_level_next = 1'b1; delay_count_next = qd; phase_next = i2c_pkg::PH_A1;
              end
              i2c_pkg::PH_A1: begin
                scl_level_next = 1'b1; delay_count_next = qd; phase_next = i2c_pkg::PH_A2;
              end
              i2c_pkg::PH_A2: begin
                delay_count_next = qd;
                phase_next = item.sda_in ? i2c_pkg::PH_A3NK : i2c_pkg::PH_A3OK;
              end
              i2c_pkg::PH_A3NK: begin
                scl_level_next = 1'b0; delay_count_next = qd; nack_seen_next = 1'b1;
                phase_next = i2c_pkg::PH_P0;
              end
              i2c_pkg::PH_A3OK: begin
                scl_level_next = 1'b0; delay_count_next = qd;
                if (read_part) begin
                  if (reads_left != '0) begin
                    bit_index_next = 3'd7; phase_next = i2c_pkg::PH_R0;
                  end else begin
                    phase_next = i2c_pkg::PH_P0;
                  end
                end else if (byte_index < write_count) begin
                  shift_reg_next = buf_rd;
                  byte_index_next = byte_index + FillW'(1);
                  bit_index_next = 3'd7; phase_next = i2c_pkg::PH_W0;
                end else if (active_mode == i2c_pkg::MODE_WR_RD) begin
                  read_part_next = 1'b1; phase_next = i2c_pkg::PH_S0;
                end else begin
                  phase_next = i2c_pkg::PH_P0;
                end
              end
              i2c_pkg::PH_R0: begin
                sda_level_next = 1'b1; scl_level_next = 1'b1; delay_count_next = qd;
                phase_next = i2c_pkg::PH_R1;
              end
              i2c_pkg::PH_R1: begin
                shift_reg_next = {shift_reg[6:0], item.sda_in}; delay_count_next = qd;
                phase_next = i2c_pkg::PH_R2;
              end
              i2c_pkg::PH_R2: begin
                scl_level_next = 1'b0; delay_count_next = hd;
                if (bit_index == 3'd0) begin
                  phase_next = i2c_pkg::PH_K0;
                end else begin
                  bit_index_next = bit_index - 3'd1; phase_next = i2c_pkg::PH_R0;
                end
              end
              i2c_pkg::PH_K0: begin
                sda_level_next = (reads_left > RdW'(1)) ? 1'b0 : 1'b1;
                delay_count_next = qd;
                res_next.rd_valid = 1'b1;
                res_next.rd_data = shift_reg;
                res_next.rd_last = (reads_left <= RdW'(1));
                phase_next = i2c_pkg::PH_K1;
              end
              i2c_pkg::PH_K1: begin
                scl_level_next = 1'b1; delay_count_next = hd; phase_next = i2c_pkg::PH_K2;
              end
              i2c_pkg::PH_K2: begin
                scl_level_next = 1'b0; delay_count_next = qd;
                if (reads_left > RdW'(1)) begin
                  reads_left_next = reads_left - RdW'(1);
                  bit_index_next = 3'd7; phase_next = i2c_pkg::PH_R0;
                end else begin
                  reads_left_next = '0; phase_next = i2c_pkg::PH_P0;
                end
              end
              i2c_pkg::PH_P0: begin
                sda_level_next = 1'b0; scl_level_next = 1'b1; delay_count_next = hd;
                phase_next = i2c_pkg::PH_P1;
              end
              i2c_pkg::PH_P1: begin
                sda_level_next = 1'b1; delay_count_next = hd; phase_next = i2c_pkg::PH_FIN;
              end
              i2c_pkg::PH_FIN: begin
                delay_count_next = 16'd0;
                res_next.done_res = 1'b1;
                res_next.status = nack_seen ? i2c_pkg::ST_NACK : i2c_pkg::ST_OK;
                phase_next = i2c_pkg::PH_IDLE;
              end
              default: begin
                phase_next = i2c_pkg::PH_IDLE; delay_count_next = 16'd0;
              end
            endcase
          end
        end
      end
      i2c_pkg::REQ_LOAD: begin
        if (phase == i2c_pkg::PH_IDLE && buffer_fill < FillW'(WriteBufDepth)) begin
          wr_en = 1'b1;
          buffer_fill_next = buffer_fill + FillW'(1);
        end
      end
      i2c_pkg::REQ_LAUNCH: begin
        if (phase == i2c_pkg::PH_IDLE) begin
          buffer_fill_next = '0;
          bad = !bus_enable || (item.xfer_mode == 2'd3)
             || (item.xfer_mode == i2c_pkg::MODE_WRITE && item.write_len == 5'd0)
             || (item.xfer_mode == i2c_pkg::MODE_READ && item.read_len == 8'd0)
             || (item.xfer_mode != i2c_pkg::MODE_READ
                 && {27'd0, item.write_len} > 32'(WriteBufDepth));
          if (bad) begin
            res_next.done_res = 1'b1;
            res_next.status = i2c_pkg::ST_INVALID;
          end else begin
            target_address_next = item.dev_address;
            active_mode_next = item.xfer_mode;
            write_count_next = (item.xfer_mode == i2c_pkg::MODE_READ) ? '0
                             : FillW'(item.write_len);
            reads_left_next = (item.xfer_mode == i2c_pkg::MODE_WRITE) ? '0 : rlen_sat;
            read_part_next = (item.xfer_mode == i2c_pkg::MODE_READ);
            byte_index_next = '0;
            bit_index_next = 3'd0;
            nack_seen_next = 1'b0;
            delay_count_next = 16'd0;
            phase_next = i2c_pkg::PH_S0;
          end
        end
      end
      default: begin
      end
    endcase
    res_next.scl_out = scl_level_next;
    res_next.sda_out = sda_level_next;
    res_next.busy_res = (phase_next != i2c_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (take && wr_en) begin
      wbuf[buffer_fill[BufAw-1:0]] <= item.wr_byte;
    end
    if (take) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= i2c_pkg::PH_IDLE;
      delay_count <= '0;
      bit_index <= '0;
      shift_reg <= '0;
      buffer_fill <= '0;
      byte_index <= '0;
      write_count <= '0;
      reads_left <= '0;
      target_address <= '0;
      active_mode <= '0;
      scl_level <= 1'b1;
      sda_level <= 1'b1;
      read_part <= 1'b0;
      nack_seen <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next;
        delay_count <= delay_count_next;
        bit_index <= bit_index_next;
        shift_reg <= shift_reg_next;
        buffer_fill <= buffer_fill_next;
        byte_index <= byte_index_next;
        write_count <= write_count_next;
        reads_left <= reads_left_next;
        target_address <= target_address_next;
        active_mode <= active_mode_next;
        scl_level <= scl_level_next;
        sda_level <= sda_level_next;
        read_part <= read_part_next;
        nack_seen <= nack_seen_next;
      end
      if (take) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

>>> design/i2c_master_transaction_engine.sv
`default_nettype none
// I2C master transaction engine. Every input item (time tick, buffer load or
// launch) yields exactly one result item carrying the SCL/SDA drive levels,
// busy, any received byte and the done status. A two-entry queue sits between
// the input port and the bus sequencer, and the sequencer takes one item per
// clock cycle into a registered result, so the sustained rate is one item per
// cycle while the output is not stalled; each item passes through a queue entry
// and then the result register. Registers are written through the config
// channel, which is always ready.
`include "i2c_master_transaction_engine_defines.svh"
module i2c_master_transaction_engine #(
  parameter int WriteBufDepth = i2c_pkg::WriteBufDepth,
  parameter int MaxReadLen = i2c_pkg::MaxReadLen
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire i2c_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output i2c_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data
);
  logic [15:0] half_period_ticks;
  logic        bus_enable;
  logic        q_valid;
  logic        q_ready;
  i2c_pkg::in_item_t q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= 16'd5;
      bus_enable <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        i2c_pkg::CFG_HALF_PERIOD: half_period_ticks <= cfg_data;
        i2c_pkg::CFG_ENABLE: bus_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  i2c_fifo #(.Width($bits(i2c_pkg::in_item_t))) u_fifo (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  i2c_engine #(.WriteBufDepth(WriteBufDepth), .MaxReadLen(MaxReadLen)) u_engine (
    .clk(clk), .rst(rst),
    .item_valid(q_valid), .item_ready(q_ready), .item(q_data),
    .half_period_ticks(half_period_ticks), .bus_enable(bus_enable),
    .res_valid(out_valid), .res_ready(out_ready), .res(out_data)
  );

  `I2C_ASSERT_NEXT(a_take_gives_result, clk, rst, q_valid && q_ready, out_valid,
    "accepted item produced no result")
  `I2C_ASSERT_IMPL(a_done_not_busy, clk, rst, out_valid && out_data.done_res,
    !out_data.busy_res, "done while busy")
  `I2C_ASSERT_IMPL(a_status_clean, clk, rst, out_valid && !out_data.done_res,
    out_data.status == i2c_pkg::ST_OK, "status without done")
endmodule
`default_nettype wire

>>> tb/i2c_master_transaction_engine_tb.sv
`default_nettype none
module i2c_master_transaction_engine_tb;
  import i2c_pkg::*;

  localparam int CycleLimit = 3000000;

  typedef struct {
    phase_t           ph;
    logic [15:0]      dly;
    logic [3:0]       bitn;
    logic [7:0]       sh;
    logic [15:0][7:0] wbuf;
    logic [4:0]       fill;
    logic [7:0]       bidx;
    logic [7:0]       rleft;
    logic [6:0]       addr;
    logic [1:0]       mode;
    logic             scl;
    logic             sda;
    logic [4:0]       wcnt;
    logic             rpart;
    logic             nack;
    logic [15:0]      half;
    logic             en;
  } engine_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  in_item_t  pend_q[$];
  out_item_t bus_q[$];
  engine_t   chk_s;
  engine_t   gen_s;
  int        errs;
  int        cycles;
  int        snd_pct;
  int        rcv_pct;
  int        items;
  bit        in_taken;

  i2c_master_transaction_engine DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic void engine_reset(output engine_t s);
    s.ph = PH_IDLE; s.dly = '0; s.bitn = '0; s.sh = '0; s.wbuf = '0; s.fill = '0;
    s.bidx = '0; s.rleft = '0; s.addr = '0; s.mode = '0; s.scl = 1'b1; s.sda = 1'b1;
    s.wcnt = '0; s.rpart = 1'b0; s.nack = 1'b0; s.half = 16'd5; s.en = 1'b0;
  endfunction

  function automatic logic [15:0] hold_for(logic [15:0] d);
    return (d == 16'd0) ? 16'd0 : d - 16'd1;
  endfunction

  // One item in, one bus result out.
  function automatic void engine_step(inout engine_t s, input in_item_t x,
                                      output out_item_t o);
    logic [15:0] h;
    logic [15:0] q;
    logic [7:0]  rlen;
    logic        bad;
    h = s.half;
    q = s.half >> 1;
    o = '0;
    if (x.req_type == REQ_TICK) begin
      if (s.ph != PH_IDLE) begin
        if (s.dly != 16'd0) begin
          s.dly = s.dly - 16'd1;
        end else begin
          case (s.ph)
            PH_S0: begin s.sda = 1'b1; s.scl = 1'b1; s.dly = hold_for(h); s.ph = PH_S1; end
            PH_S1: begin s.sda = 1'b0; s.dly = hold_for(h); s.ph = PH_S2; end
            PH_S2: begin
              s.scl = 1'b0; s.dly = hold_for(h);
              s.sh = {s.addr, s.rpart}; s.bitn = 4'd7; s.ph = PH_W0;
            end
            PH_W0: begin s.sda = s.sh[s.bitn[2:0]]; s.dly = hold_for(q); s.ph = PH_W1; end
            PH_W1: begin s.scl = 1'b1; s.dly = hold_for(h); s.ph = PH_W2; end
            PH_W2: begin
              s.scl = 1'b0; s.dly = hold_for(q);
              if (s.bitn == 4'd0) begin
                s.ph = PH_A0;
              end else begin
                s.bitn = s.bitn - 4'd1; s.ph = PH_W0;
              end
            end
            PH_A0: begin s.sda = 1'b1; s.dly = hold_for(q); s.ph = PH_A1; end
            PH_A1: begin s.scl = 1'b1; s.dly = hold_for(q); s.ph = PH_A2; end
            PH_A2: begin s.dly = hold_for(q); s.ph = x.sda_in ? PH_A3NK : PH_A3OK; end
            PH_A3NK: begin s.scl = 1'b0; s.dly = hold_for(q); s.nack = 1'b1; s.ph = PH_P0; end
            PH_A3OK: begin
              s.scl = 1'b0; s.dly = hold_for(q);
              if (s.rpart) begin
                if (s.rleft != 8'd0) begin
                  s.bitn = 4'd7; s.ph = PH_R0;
                end else begin
                  s.ph = PH_P0;
                end
              end else if (s.bidx < 8'(s.wcnt) && s.bidx < 8'(WriteBufDepth)) begin
                s.sh = s.wbuf[s.bidx[3:0]]; s.bidx = s.bidx + 8'd1;
                s.bitn = 4'd7; s.ph = PH_W0;
              end else if (s.mode == MODE_WR_RD) begin
                s.rpart = 1'b1; s.ph = PH_S0;
              end else begin
                s.ph = PH_P0;
              end
            end
            PH_R0: begin s.sda = 1'b1; s.scl = 1'b1; s.dly = hold_for(q); s.ph = PH_R1; end
            PH_R1: begin s.sh = {s.sh[6:0], x.sda_in}; s.dly = hold_for(q); s.ph = PH_R2; end
            PH_R2: begin
              s.scl = 1'b0; s.dly = hold_for(h);
              if (s.bitn == 4'd0) begin
                s.ph = PH_K0;
              end else begin
                s.bitn = s.bitn - 4'd1; s.ph = PH_R0;
              end
            end
            PH_K0: begin
              s.sda = (s.rleft > 8'd1) ? 1'b0 : 1'b1; s.dly = hold_for(q);
              o.rd_valid = 1'b1; o.rd_data = s.sh; o.rd_last = (s.rleft <= 8'd1);
              s.ph = PH_K1;
            end
            PH_K1: begin s.scl = 1'b1; s.dly = hold_for(h); s.ph = PH_K2; end
            PH_K2: begin
              s.scl = 1'b0; s.dly = hold_for(q);
              if (s.rleft != 8'd0) s.rleft = s.rleft - 8'd1;
              if (s.rleft != 8'd0) begin
                s.bitn = 4'd7; s.ph = PH_R0;
              end else begin
                s.ph = PH_P0;
              end
            end
            PH_P0: begin s.sda = 1'b0; s.scl = 1'b1; s.dly = hold_for(h); s.ph = PH_P1; end
            PH_P1: begin s.sda = 1'b1; s.dly = hold_for(h); s.ph = PH_FIN; end
            PH_FIN: begin
              s.dly = '0; o.done_res = 1'b1; o.status = s.nack ? ST_NACK : ST_OK;
              s.ph = PH_IDLE;
            end
            default: begin s.ph = PH_IDLE; s.dly = '0; end
          endcase
        end
      end
    end else if (x.req_type == REQ_LOAD) begin
      if (s.ph == PH_IDLE && s.fill < 5'(WriteBufDepth)) begin
        s.wbuf[s.fill[3:0]] = x.wr_byte;
        s.fill = s.fill + 5'd1;
      end
    end else if (x.req_type == REQ_LAUNCH && s.ph == PH_IDLE) begin
      s.fill = '0;
      bad = !s.en || x.xfer_mode == 2'd3
            || (x.xfer_mode == MODE_WRITE && x.write_len == 5'd0)
            || (x.xfer_mode == MODE_READ && x.read_len == 8'd0)
            || (x.xfer_mode != MODE_READ && x.write_len > 5'(WriteBufDepth));
      if (bad) begin
        o.done_res = 1'b1; o.status = ST_INVALID;
      end else begin
        rlen = (x.read_len > 8'(MaxReadLen)) ? 8'(MaxReadLen) : x.read_len;
        s.addr = x.dev_address;
        s.mode = x.xfer_mode;
        s.wcnt = (x.xfer_mode == MODE_READ) ? 5'd0 : x.write_len;
        s.rleft = (x.xfer_mode == MODE_WRITE) ? 8'd0 : rlen;
        s.rpart = (x.xfer_mode == MODE_READ);
        s.bidx = '0; s.bitn = '0; s.nack = 1'b0; s.dly = '0;
        s.ph = PH_S0;
      end
    end
    o.scl_out = s.scl;
    o.sda_out = s.sda;
    o.busy_res = (s.ph != PH_IDLE);
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("i2c_master_transaction_engine_tb NOT OK");
      $finish;
    end
  end

  // Input side: predict on each transfer.
  always @(posedge clk) begin
    out_item_t o;
    if (!rst && in_valid && in_ready) begin
      engine_step(chk_s, in_data, o);
      bus_q.push_back(o);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    logic nv;
    nv = in_valid;
    if (!rst && (!in_valid || in_taken)) begin
      nv = 1'b0;
      if (pend_q.size() != 0 && $urandom_range(0, 99) >= snd_pct) begin
        nv = 1'b1;
        in_data <= pend_q.pop_front();
      end
    end
    in_taken = 1'b0;
    in_valid <= nv;
    out_ready <= !rst && ($urandom_range(0, 99) >= rcv_pct);
  end

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (bus_q.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        errs++;
      end else begin
        e = bus_q.pop_front();
        if (out_data.scl_out !== e.scl_out) begin
          $error("scl_out exp %0d got %0d", e.scl_out, out_data.scl_out); errs++;
        end
        if (out_data.sda_out !== e.sda_out) begin
          $error("sda_out exp %0d got %0d", e.sda_out, out_data.sda_out); errs++;
        end
        if (out_data.busy_res !== e.busy_res) begin
          $error("busy_res exp %0d got %0d", e.busy_res, out_data.busy_res); errs++;
        end
        if (out_data.rd_valid !== e.rd_valid) begin
          $error("rd_valid exp %0d got %0d", e.rd_valid, out_data.rd_valid); errs++;
        end
        if (out_data.rd_data !== e.rd_data) begin
          $error("rd_data exp %h got %h", e.rd_data, out_data.rd_data); errs++;
        end
        if (out_data.rd_last !== e.rd_last) begin
          $error("rd_last exp %0d got %0d", e.rd_last, out_data.rd_last); errs++;
        end
        if (out_data.done_res !== e.done_res) begin
          $error("done_res exp %0d got %0d", e.done_res, out_data.done_res); errs++;
        end
        if (out_data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data.status); errs++;
        end
      end
    end
  end

  task automatic queue_item(in_item_t x);
    out_item_t o;
    pend_q.push_back(x);
    engine_step(gen_s, x, o);
    items++;
  endtask

  // Wait for every queued transfer and expected result, then let the pipe settle.
  task automatic drain();
    while (pend_q.size() != 0 || in_valid || bus_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_HALF_PERIOD) begin
      chk_s.half = val; gen_s.half = val;
    end else begin
      chk_s.en = val[0]; gen_s.en = val[0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_byte(logic [7:0] b);
    in_item_t x;
    x = in_item_t'($urandom);
    x.req_type = REQ_LOAD;
    x.wr_byte = b;
    queue_item(x);
  endtask

  // Launch, then tick until the stop is done; sprinkle ignored items while busy.
  task automatic run_transfer(logic [1:0] mode, logic [6:0] addr, logic [4:0] wlen,
                              logic [7:0] rlen, int nloads, bit nack_all);
    in_item_t x;
    repeat (nloads) load_byte(8'($urandom));
    x = in_item_t'($urandom);
    x.req_type = REQ_LAUNCH;
    x.dev_address = addr;
    x.xfer_mode = mode;
    x.write_len = wlen;
    x.read_len = rlen;
    queue_item(x);
    while (gen_s.ph != PH_IDLE) begin
      x = in_item_t'($urandom);
      if ($urandom_range(0, 39) == 0) begin
        x.req_type = 2'($urandom_range(1, 3));
      end else begin
        x.req_type = REQ_TICK;
        if (gen_s.ph == PH_A2 && gen_s.dly == 16'd0)
          x.sda_in = nack_all ? 1'b1 : ($urandom_range(0, 29) == 0);
      end
      queue_item(x);
    end
    repeat ($urandom_range(0, 3)) begin
      x = in_item_t'($urandom);
      x.req_type = REQ_TICK;
      queue_item(x);
    end
  endtask

  initial begin
    in_item_t x;
    int goal;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_HALF_PERIOD;
    cfg_data = '0;
    errs = 0;
    cycles = 0;
    items = 0;
    in_taken = 1'b0;
    snd_pct = 0;
    rcv_pct = 0;
    engine_reset(chk_s);
    engine_reset(gen_s);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill every buffer entry once; extremes of the byte value.
    load_byte(8'h00);
    load_byte(8'hFF);
    repeat (14) load_byte(8'($urandom));
    load_byte(8'hA5);
    x = '0;
    x.req_type = 2'd3;
    queue_item(x);
    x.req_type = REQ_TICK;
    x.sda_in = 1'b1;
    queue_item(x);
    run_transfer(MODE_WRITE, 7'h55, 5'd2, 8'd0, 0, 1'b0);

    write_reg(CFG_HALF_PERIOD, 16'hFFFF);
    run_transfer(MODE_READ, 7'h7F, 5'd0, 8'd1, 0, 1'b0);
    write_reg(CFG_ENABLE, 16'd1);
    run_transfer(2'd3, 7'h00, 5'd1, 8'd1, 0, 1'b0);
    write_reg(CFG_HALF_PERIOD, 16'd1);
    run_transfer(MODE_WRITE, 7'h00, 5'd0, 8'd3, 0, 1'b0);
    run_transfer(MODE_READ, 7'h00, 5'd3, 8'd0, 0, 1'b0);
    run_transfer(MODE_WRITE, 7'h00, 5'd17, 8'd0, 0, 1'b0);
    run_transfer(MODE_WR_RD, 7'h00, 5'd31, 8'd1, 0, 1'b0);
    // Full-buffer length is valid; the target refuses the address.
    run_transfer(MODE_WRITE, 7'h7F, 5'd16, 8'd0, 0, 1'b1);
    run_transfer(MODE_READ, 7'h00, 5'd0, 8'd3, 0, 1'b0);
    run_transfer(MODE_WR_RD, 7'h2A, 5'd0, 8'd0, 0, 1'b0);
    run_transfer(MODE_WRITE, 7'h3C, 5'd2, 8'd0, 0, 1'b1);
    write_reg(CFG_HALF_PERIOD, 16'd0);
    run_transfer(MODE_WR_RD, 7'h41, 5'd1, 8'd2, 0, 1'b0);

    goal = items;
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_HALF_PERIOD, 16'($urandom_range(0, 3)));
      write_reg(CFG_ENABLE, 16'd1);
      case (p)
        0: begin snd_pct = 0;  rcv_pct = 0;  end
        1: begin snd_pct = 51; rcv_pct = 0;  end
        2: begin snd_pct = 0;  rcv_pct = 51; end
        default: begin snd_pct = 37; rcv_pct = 37; end
      endcase
      goal += 75;
      while (items < goal) begin
        logic [1:0] m;
        logic [4:0] wl;
        logic [7:0] rl;
        m = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        wl = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
           : ($urandom_range(0, 9) == 0) ? 5'd16 : 5'($urandom_range(0, 4));
        rl = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 6))
                                         : 8'($urandom_range(1, 3));
        run_transfer(m, 7'($urandom), wl, rl, $urandom_range(0, 18),
                     $urandom_range(0, 9) == 0);
      end
      // Hold the sender until every expected result has come.
      drain();
    end

    drain();
    if (errs == 0) begin
      $display("i2c_master_transaction_engine_tb OK");
    end else begin
      $display("i2c_master_transaction_engine_tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+design
design/i2c_pkg.sv
design/i2c_fifo.sv
design/i2c_engine.sv
design/i2c_master_transaction_engine.sv
tb/i2c_master_transaction_engine_tb.sv
